>>> rtl/obb_pkg.sv
`timescale 1ns / 1ps
package obb_pkg;

  localparam int COORD_BITS         = 16;
  localparam int ANGLE_BITS         = 12;
  localparam int TRIG_FRACTION_BITS = 14;

  localparam int HALF_W   = COORD_BITS - 1;
  localparam int QUARTER  = 1 << (ANGLE_BITS - 2);
  localparam int RES_W    = ANGLE_BITS - 2;
  localparam int ROM_AW   = ANGLE_BITS - 1;
  localparam int ROM_W    = TRIG_FRACTION_BITS + 1;
  localparam int TRIG_W   = TRIG_FRACTION_BITS + 2;
  localparam int DIFF_W   = COORD_BITS + 1;
  localparam int PROD_W   = DIFF_W + TRIG_W;
  localparam int DIST_W   = PROD_W + 1;
  localparam int TT_W     = 2 * TRIG_W;
  localparam int DOT_W    = TT_W + 1;
  localparam int D_W      = TRIG_FRACTION_BITS + 2;
  localparam int EP_W     = HALF_W + D_W;
  localparam int SUM_W    = EP_W + 2;
  localparam int PIPE_LAT = 8;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;

  typedef enum logic [2:0] {
    AXIS_A_WIDTH  = 3'd0,
    AXIS_A_HEIGHT = 3'd1,
    AXIS_B_WIDTH  = 3'd2,
    AXIS_B_HEIGHT = 3'd3,
    AXIS_NONE     = 3'd4
  } axis_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_center_x;
    logic signed [COORD_BITS-1:0] a_center_y;
    logic        [HALF_W-1:0]     a_half_width;
    logic        [HALF_W-1:0]     a_half_height;
    logic        [ANGLE_BITS-1:0] a_angle;
    logic signed [COORD_BITS-1:0] b_center_x;
    logic signed [COORD_BITS-1:0] b_center_y;
    logic        [HALF_W-1:0]     b_half_width;
    logic        [HALF_W-1:0]     b_half_height;
    logic        [ANGLE_BITS-1:0] b_angle;
  } obb_in_t;

  typedef struct packed {
    logic       overlap;
    logic [2:0] separating_axis;
  } obb_out_t;

  typedef struct packed {
    logic [HALF_W-1:0] aw;
    logic [HALF_W-1:0] ah;
    logic [HALF_W-1:0] bw;
    logic [HALF_W-1:0] bh;
  } obb_ext_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    obb_ext_t                 ext;
  } obb_geom_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] ca;
    logic signed [TRIG_W-1:0] sa;
    logic signed [TRIG_W-1:0] cb;
    logic signed [TRIG_W-1:0] sb;
  } obb_trig_t;

  // dist: projected center distance per axis; d_*: rounded |axis . axis|
  typedef struct packed {
    logic [DIST_W-1:0] dist0;
    logic [DIST_W-1:0] dist1;
    logic [DIST_W-1:0] dist2;
    logic [DIST_W-1:0] dist3;
    logic [D_W-1:0]    d_aa;
    logic [D_W-1:0]    d_bb;
    logic [D_W-1:0]    d_p;
    logic [D_W-1:0]    d_q;
  } obb_proj_t;

  typedef logic [ROM_W-1:0] rom_tab_t [QUARTER+1];

  // Quarter-wave sine in Q1.F, Horner series on a Q30 angle.
  function automatic rom_tab_t build_sine_rom();
    rom_tab_t          tab;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   t;
    longint unsigned   s;
    for (int r = 0; r <= QUARTER; r++) begin
      x  = (64'(r) * HALF_PI_Q30) >> (ANGLE_BITS - 2);
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
      s  = (x * t) >> 30;
      tab[r] = ROM_W'((s + (64'd1 << (29 - TRIG_FRACTION_BITS)))
                      >> (30 - TRIG_FRACTION_BITS));
    end
    return tab;
  endfunction

endpackage

>>> rtl/obb_trig.sv
`timescale 1ns / 1ps
module obb_trig (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  input  obb_pkg::obb_in_t  req,
  output logic              trig_valid,
  output obb_pkg::obb_trig_t trig,
  output obb_pkg::obb_geom_t geom
);
  import obb_pkg::*;

  localparam rom_tab_t ROM_A = build_sine_rom();
  localparam rom_tab_t ROM_B = build_sine_rom();

  // {negate, quarter-table address}
  function automatic logic [ROM_AW:0] rom_lookup(input logic [ANGLE_BITS-1:0] p);
    logic [RES_W-1:0]  r;
    logic [ROM_AW-1:0] addr;
    r    = p[RES_W-1:0];
    addr = p[ANGLE_BITS-2] ? (ROM_AW'(QUARTER) - {1'b0, r}) : {1'b0, r};
    return {p[ANGLE_BITS-1], addr};
  endfunction

  function automatic logic signed [TRIG_W-1:0] apply_sign(input logic [ROM_W-1:0] mag,
                                                          input logic neg);
    logic signed [TRIG_W-1:0] v;
    v = $signed({1'b0, mag});
    return neg ? -v : v;
  endfunction

  logic [ROM_AW:0] lk_ca, lk_sa, lk_cb, lk_sb;

  logic              v1_r, v2_r;
  logic [ROM_W-1:0]  mag_ca_r, mag_sa_r, mag_cb_r, mag_sb_r;
  logic              neg_ca_r, neg_sa_r, neg_cb_r, neg_sb_r;
  obb_geom_t         geom1_nxt, geom1_r, geom2_r;
  obb_trig_t         trig2_nxt, trig2_r;

  always_comb begin
    lk_ca = rom_lookup(req.a_angle + ANGLE_BITS'(QUARTER));
    lk_sa = rom_lookup(req.a_angle);
    lk_cb = rom_lookup(req.b_angle + ANGLE_BITS'(QUARTER));
    lk_sb = rom_lookup(req.b_angle);

    geom1_nxt.dx     = DIFF_W'(req.b_center_x) - DIFF_W'(req.a_center_x);
    geom1_nxt.dy     = DIFF_W'(req.b_center_y) - DIFF_W'(req.a_center_y);
    geom1_nxt.ext.aw = req.a_half_width;
    geom1_nxt.ext.ah = req.a_half_height;
    geom1_nxt.ext.bw = req.b_half_width;
    geom1_nxt.ext.bh = req.b_half_height;

    trig2_nxt.ca = apply_sign(mag_ca_r, neg_ca_r);
    trig2_nxt.sa = apply_sign(mag_sa_r, neg_sa_r);
    trig2_nxt.cb = apply_sign(mag_cb_r, neg_cb_r);
    trig2_nxt.sb = apply_sign(mag_sb_r, neg_sb_r);
  end

  // Two read ports per table: cos and sin of one box.
  always_ff @(posedge clk) begin
    mag_ca_r <= ROM_A[lk_ca[ROM_AW-1:0]];
    mag_sa_r <= ROM_A[lk_sa[ROM_AW-1:0]];
    mag_cb_r <= ROM_B[lk_cb[ROM_AW-1:0]];
    mag_sb_r <= ROM_B[lk_sb[ROM_AW-1:0]];
    neg_ca_r <= lk_ca[ROM_AW];
    neg_sa_r <= lk_sa[ROM_AW];
    neg_cb_r <= lk_cb[ROM_AW];
    neg_sb_r <= lk_sb[ROM_AW];
    geom1_r  <= geom1_nxt;
    trig2_r  <= trig2_nxt;
    geom2_r  <= geom1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= req_valid;
      v2_r <= v1_r;
    end
  end

  assign trig_valid = v2_r;
  assign trig       = trig2_r;
  assign geom       = geom2_r;

endmodule

>>> rtl/obb_proj.sv
`timescale 1ns / 1ps
module obb_proj (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               trig_valid,
  input  obb_pkg::obb_trig_t trig,
  input  obb_pkg::obb_geom_t geom,
  output logic               proj_valid,
  output obb_pkg::obb_proj_t proj,
  output obb_pkg::obb_ext_t  ext
);
  import obb_pkg::*;

  function automatic logic [DIST_W-1:0] abs_dist(input logic signed [DIST_W-1:0] v);
    return v[DIST_W-1] ? DIST_W'(-v) : DIST_W'(v);
  endfunction

  // |dot| in Q2F rounded half up to QF
  function automatic logic [D_W-1:0] round_dot(input logic signed [DOT_W-1:0] v);
    logic [DOT_W-1:0] mag;
    logic [DOT_W:0]   rnd;
    mag = v[DOT_W-1] ? DOT_W'(-v) : DOT_W'(v);
    rnd = {1'b0, mag} + ((DOT_W+1)'(1) << (TRIG_FRACTION_BITS - 1));
    return rnd[TRIG_FRACTION_BITS +: D_W];
  endfunction

  logic v1_r, v2_r, v3_r;

  // stage 1: products
  logic signed [PROD_W-1:0] m_dx_ca_r, m_dy_sa_r, m_dx_sa_r, m_dy_ca_r;
  logic signed [PROD_W-1:0] m_dx_cb_r, m_dy_sb_r, m_dx_sb_r, m_dy_cb_r;
  logic signed [TT_W-1:0]   m_ca_ca_r, m_sa_sa_r, m_cb_cb_r, m_sb_sb_r;
  logic signed [TT_W-1:0]   m_ca_cb_r, m_sa_sb_r, m_sa_cb_r, m_ca_sb_r;
  obb_ext_t                 ext1_r, ext2_r, ext3_r;

  // stage 2: sums
  logic signed [DIST_W-1:0] s_d0_r, s_d1_r, s_d2_r, s_d3_r;
  logic signed [DOT_W-1:0]  s_aa_r, s_bb_r, s_p_r, s_q_r;

  // stage 3: magnitudes
  obb_proj_t proj3_nxt, proj3_r;

  always_ff @(posedge clk) begin
    m_dx_ca_r <= PROD_W'(geom.dx) * PROD_W'(trig.ca);
    m_dy_sa_r <= PROD_W'(geom.dy) * PROD_W'(trig.sa);
    m_dx_sa_r <= PROD_W'(geom.dx) * PROD_W'(trig.sa);
    m_dy_ca_r <= PROD_W'(geom.dy) * PROD_W'(trig.ca);
    m_dx_cb_r <= PROD_W'(geom.dx) * PROD_W'(trig.cb);
    m_dy_sb_r <= PROD_W'(geom.dy) * PROD_W'(trig.sb);
    m_dx_sb_r <= PROD_W'(geom.dx) * PROD_W'(trig.sb);
    m_dy_cb_r <= PROD_W'(geom.dy) * PROD_W'(trig.cb);
    m_ca_ca_r <= TT_W'(trig.ca) * TT_W'(trig.ca);
    m_sa_sa_r <= TT_W'(trig.sa) * TT_W'(trig.sa);
    m_cb_cb_r <= TT_W'(trig.cb) * TT_W'(trig.cb);
    m_sb_sb_r <= TT_W'(trig.sb) * TT_W'(trig.sb);
    m_ca_cb_r <= TT_W'(trig.ca) * TT_W'(trig.cb);
    m_sa_sb_r <= TT_W'(trig.sa) * TT_W'(trig.sb);
    m_sa_cb_r <= TT_W'(trig.sa) * TT_W'(trig.cb);
    m_ca_sb_r <= TT_W'(trig.ca) * TT_W'(trig.sb);
    ext1_r    <= geom.ext;

    s_d0_r <= DIST_W'(m_dx_ca_r) + DIST_W'(m_dy_sa_r);
    s_d1_r <= DIST_W'(m_dy_ca_r) - DIST_W'(m_dx_sa_r);
    s_d2_r <= DIST_W'(m_dx_cb_r) + DIST_W'(m_dy_sb_r);
    s_d3_r <= DIST_W'(m_dy_cb_r) - DIST_W'(m_dx_sb_r);
    s_aa_r <= DOT_W'(m_ca_ca_r) + DOT_W'(m_sa_sa_r);
    s_bb_r <= DOT_W'(m_cb_cb_r) + DOT_W'(m_sb_sb_r);
    s_p_r  <= DOT_W'(m_ca_cb_r) + DOT_W'(m_sa_sb_r);
    s_q_r  <= DOT_W'(m_sa_cb_r) - DOT_W'(m_ca_sb_r);
    ext2_r <= ext1_r;

    proj3_r <= proj3_nxt;
    ext3_r  <= ext2_r;
  end

  always_comb begin
    proj3_nxt.dist0 = abs_dist(s_d0_r);
    proj3_nxt.dist1 = abs_dist(s_d1_r);
    proj3_nxt.dist2 = abs_dist(s_d2_r);
    proj3_nxt.dist3 = abs_dist(s_d3_r);
    proj3_nxt.d_aa  = round_dot(s_aa_r);
    proj3_nxt.d_bb  = round_dot(s_bb_r);
    proj3_nxt.d_p   = round_dot(s_p_r);
    proj3_nxt.d_q   = round_dot(s_q_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= trig_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign proj_valid = v3_r;
  assign proj       = proj3_r;
  assign ext        = ext3_r;

endmodule

>>> rtl/obb_sep.sv
`timescale 1ns / 1ps
module obb_sep (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               proj_valid,
  input  obb_pkg::obb_proj_t proj,
  input  obb_pkg::obb_ext_t  ext,
  output logic               res_valid,
  output obb_pkg::obb_out_t  res
);
  import obb_pkg::*;

  logic v1_r, v2_r, v3_r;

  // stage 1: half extent times rounded axis cosine
  logic [EP_W-1:0] e_aw_aa_r, e_aw_p_r, e_aw_q_r;
  logic [EP_W-1:0] e_ah_aa_r, e_ah_p_r, e_ah_q_r;
  logic [EP_W-1:0] e_bw_bb_r, e_bw_p_r, e_bw_q_r;
  logic [EP_W-1:0] e_bh_bb_r, e_bh_p_r, e_bh_q_r;
  logic [DIST_W-1:0] dist0_r, dist1_r, dist2_r, dist3_r;

  // stage 2: radius sums and compare
  logic [SUM_W-1:0] rad0, rad1, rad2, rad3;
  logic [3:0]       sep_nxt, sep_r;

  // stage 3: first separating axis
  obb_out_t res_nxt, res_r;

  always_ff @(posedge clk) begin
    e_aw_aa_r <= EP_W'(ext.aw) * EP_W'(proj.d_aa);
    e_aw_p_r  <= EP_W'(ext.aw) * EP_W'(proj.d_p);
    e_aw_q_r  <= EP_W'(ext.aw) * EP_W'(proj.d_q);
    e_ah_aa_r <= EP_W'(ext.ah) * EP_W'(proj.d_aa);
    e_ah_p_r  <= EP_W'(ext.ah) * EP_W'(proj.d_p);
    e_ah_q_r  <= EP_W'(ext.ah) * EP_W'(proj.d_q);
    e_bw_bb_r <= EP_W'(ext.bw) * EP_W'(proj.d_bb);
    e_bw_p_r  <= EP_W'(ext.bw) * EP_W'(proj.d_p);
    e_bw_q_r  <= EP_W'(ext.bw) * EP_W'(proj.d_q);
    e_bh_bb_r <= EP_W'(ext.bh) * EP_W'(proj.d_bb);
    e_bh_p_r  <= EP_W'(ext.bh) * EP_W'(proj.d_p);
    e_bh_q_r  <= EP_W'(ext.bh) * EP_W'(proj.d_q);
    dist0_r   <= proj.dist0;
    dist1_r   <= proj.dist1;
    dist2_r   <= proj.dist2;
    dist3_r   <= proj.dist3;
    sep_r     <= sep_nxt;
    res_r     <= res_nxt;
  end

  // Axes of one box are orthogonal, so each radius has three terms.
  always_comb begin
    rad0 = SUM_W'(e_aw_aa_r) + SUM_W'(e_bw_p_r) + SUM_W'(e_bh_q_r);
    rad1 = SUM_W'(e_ah_aa_r) + SUM_W'(e_bw_q_r) + SUM_W'(e_bh_p_r);
    rad2 = SUM_W'(e_aw_p_r)  + SUM_W'(e_ah_q_r) + SUM_W'(e_bw_bb_r);
    rad3 = SUM_W'(e_aw_q_r)  + SUM_W'(e_ah_p_r) + SUM_W'(e_bh_bb_r);
    sep_nxt[0] = dist0_r > DIST_W'(rad0);
    sep_nxt[1] = dist1_r > DIST_W'(rad1);
    sep_nxt[2] = dist2_r > DIST_W'(rad2);
    sep_nxt[3] = dist3_r > DIST_W'(rad3);
  end

  always_comb begin
    res_nxt.overlap = 1'b0;
    priority if (sep_r[0]) begin
      res_nxt.separating_axis = AXIS_A_WIDTH;
    end else if (sep_r[1]) begin
      res_nxt.separating_axis = AXIS_A_HEIGHT;
    end else if (sep_r[2]) begin
      res_nxt.separating_axis = AXIS_B_WIDTH;
    end else if (sep_r[3]) begin
      res_nxt.separating_axis = AXIS_B_HEIGHT;
    end else begin
      res_nxt.overlap         = 1'b1;
      res_nxt.separating_axis = AXIS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= proj_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign res_valid = v3_r;
  assign res       = res_r;

endmodule

>>> rtl/obb_overlap_test_2d_unit.sv
`timescale 1ns / 1ps
// Channel   | Ports                     | Handshake
// ----------+---------------------------+-------------------------------------
// request   | start, busy, in_req       | taken on clk when start && !busy
// result    | out_valid, out_res        | one-cycle strobe, always taken
//
// Fully pipelined: one request per cycle while busy is low; each request passes through
// the stages (sine ROM read and sign, products, sums, rounding, extent products,
// compare, priority pick). Results leave in request order.
// busy is high in reset and through the first clock edge after rst_n rises
// (sync reset); there is no stall path, since every stage advances each
// cycle and the result is never held off.
module obb_overlap_test_2d_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  obb_pkg::obb_in_t  in_req,
  output logic              out_valid,
  output obb_pkg::obb_out_t out_res
);
  import obb_pkg::*;

  logic      busy_r;
  logic      req_valid;
  logic      trig_valid;
  obb_trig_t trig;
  obb_geom_t geom;
  logic      proj_valid;
  obb_proj_t proj;
  obb_ext_t  ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign req_valid = start && !busy_r;

  obb_trig u_trig (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req        (in_req),
    .trig_valid (trig_valid),
    .trig       (trig),
    .geom       (geom)
  );

  obb_proj u_proj (
    .clk        (clk),
    .rst_n      (rst_n),
    .trig_valid (trig_valid),
    .trig       (trig),
    .geom       (geom),
    .proj_valid (proj_valid),
    .proj       (proj),
    .ext        (ext)
  );

  obb_sep u_sep (
    .clk        (clk),
    .rst_n      (rst_n),
    .proj_valid (proj_valid),
    .proj       (proj),
    .ext        (ext),
    .res_valid  (out_valid),
    .res        (out_res)
  );

endmodule

>>> rtl/obb_overlap_test_2d_unit_chk.sv
`timescale 1ns / 1ps
module obb_overlap_test_2d_unit_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input obb_pkg::obb_in_t  in_req,
  input logic              out_valid,
  input obb_pkg::obb_out_t out_res
);
  import obb_pkg::*;

  // overlap flag and axis code agree
  a_overlap_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.overlap == (out_res.separating_axis == AXIS_NONE)))
    else $error("overlap flag disagrees with axis code");

  // every taken request yields a result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("result missing after request");

  // no result without a request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result without request");

  // shared center: center distance is zero, nothing can separate
  a_same_center: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.a_center_x == in_req.b_center_x &&
     in_req.a_center_y == in_req.b_center_y)
    |-> ##PIPE_LAT (out_valid && out_res.overlap))
    else $error("boxes with a shared center reported separated");

endmodule

bind obb_overlap_test_2d_unit obb_overlap_test_2d_unit_chk u_chk (.*);

>>> tb/sv/obb_overlap_test_2d_unit_checker.sv
`timescale 1ns / 1ps
module obb_overlap_test_2d_unit_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  obb_pkg::obb_in_t  in_req,
  input  logic              out_valid,
  input  obb_pkg::obb_out_t out_res,
  output int                fail_count,
  output int                pending
);
  import obb_pkg::*;

  localparam longint unsigned HORNER_DIV [5] = '{110, 72, 42, 20, 6};
  localparam axis_t AXIS_ORDER [4] = '{AXIS_A_WIDTH, AXIS_A_HEIGHT, AXIS_B_WIDTH, AXIS_B_HEIGHT};

  longint   sine_quarter [QUARTER+1];
  obb_out_t expected_verdicts [$];

  // Q30 angle, Horner series, rounded half up to Q1.F
  function automatic longint sine_quarter_entry(int r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    x  = (longint'(r) * HALF_PI_Q30) >> RES_W;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    foreach (HORNER_DIV[k])
      t = ONE_Q30 - ((x2 * t) >> 30) / HORNER_DIV[k];
    s = (x * t) >> 30;
    return longint'((s + (64'd1 << (29 - TRIG_FRACTION_BITS))) >> (30 - TRIG_FRACTION_BITS));
  endfunction

  function automatic longint sine_at(logic [ANGLE_BITS-1:0] p);
    logic [1:0]       quad;
    logic [RES_W-1:0] r;
    quad = p[ANGLE_BITS-1 -: 2];
    r    = p[RES_W-1:0];
    case (quad)
      2'd0: return sine_quarter[r];
      2'd1: return sine_quarter[QUARTER - r];
      2'd2: return -sine_quarter[r];
      default: return -sine_quarter[QUARTER - r];
    endcase
  endfunction

  function automatic obb_out_t predict_overlap(obb_in_t req);
    obb_out_t        res;
    longint          dx;
    longint          dy;
    longint          ux [4];
    longint          uy [4];
    longint          proj;
    longint          dot;
    longint unsigned ext [4];
    longint unsigned span;
    longint unsigned reach;
    longint unsigned d1;
    bit              found;
    dx = longint'($signed(req.b_center_x)) - longint'($signed(req.a_center_x));
    dy = longint'($signed(req.b_center_y)) - longint'($signed(req.a_center_y));
    ext[0] = req.a_half_width;
    ext[1] = req.a_half_height;
    ext[2] = req.b_half_width;
    ext[3] = req.b_half_height;
    ux[0] = sine_at(ANGLE_BITS'(req.a_angle + QUARTER));
    uy[0] = sine_at(req.a_angle);
    ux[2] = sine_at(ANGLE_BITS'(req.b_angle + QUARTER));
    uy[2] = sine_at(req.b_angle);
    ux[1] = -uy[0];
    uy[1] = ux[0];
    ux[3] = -uy[2];
    uy[3] = ux[2];
    res.overlap         = 1'b1;
    res.separating_axis = AXIS_NONE;
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      proj  = dx * ux[i] + dy * uy[i];
      span  = (proj < 0) ? -proj : proj;
      reach = 0;
      for (int j = 0; j < 4; j++) begin
        dot   = ux[j] * ux[i] + uy[j] * uy[i];
        d1    = (((dot < 0) ? -dot : dot) + (64'd1 << (TRIG_FRACTION_BITS - 1)))
                >> TRIG_FRACTION_BITS;
        reach += ext[j] * d1;
      end
      // strict compare: touching boxes still overlap
      if (!found && span > reach) begin
        found               = 1'b1;
        res.overlap         = 1'b0;
        res.separating_axis = AXIS_ORDER[i];
      end
    end
    return res;
  endfunction

  initial begin
    for (int r = 0; r <= QUARTER; r++)
      sine_quarter[r] = sine_quarter_entry(r);
  end

  always @(posedge clk) begin
    obb_out_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (expected_verdicts.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result overlap=%0d axis=%0d", $time,
                   out_res.overlap, out_res.separating_axis);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_res.overlap !== want.overlap) begin
            fail_count++;
            $display("%0t: overlap expected %0d actual %0d", $time,
                     want.overlap, out_res.overlap);
          end
          if (out_res.separating_axis !== want.separating_axis) begin
            fail_count++;
            $display("%0t: separating_axis expected %0d actual %0d", $time,
                     want.separating_axis, out_res.separating_axis);
          end
        end
      end else if (out_valid !== 1'b0) begin
        fail_count++;
        $display("%0t: out_valid expected 0 or 1 actual %b", $time, out_valid);
      end
      if (start && !busy)
        expected_verdicts.insert(expected_verdicts.size(), predict_overlap(in_req));
    end else begin
      fail_count = 0;
    end
    pending = expected_verdicts.size();
  end

endmodule

>>> tb/sv/obb_overlap_test_2d_unit_tb.sv
`timescale 1ns / 1ps
module obb_overlap_test_2d_unit_tb;
  import obb_pkg::*;

  localparam int RANDOM_PER_PHASE = 517;
  localparam int PHASE_IDLE [3] = '{33, 87, 0};

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  obb_in_t           in_req;
  logic              out_valid;
  obb_out_t          out_res;
  int                fail_count;
  int                pending;
  int                sender_idle_pct;

  obb_overlap_test_2d_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  obb_overlap_test_2d_unit_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_res    (out_res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic obb_in_t box_pair(int ax, int ay, int aw, int ah, int aang,
                                       int bx, int by, int bw, int bh, int bang);
    obb_in_t req;
    req.a_center_x    = COORD_BITS'(ax);
    req.a_center_y    = COORD_BITS'(ay);
    req.a_half_width  = HALF_W'(aw);
    req.a_half_height = HALF_W'(ah);
    req.a_angle       = ANGLE_BITS'(aang);
    req.b_center_x    = COORD_BITS'(bx);
    req.b_center_y    = COORD_BITS'(by);
    req.b_half_width  = HALF_W'(bw);
    req.b_half_height = HALF_W'(bh);
    req.b_angle       = ANGLE_BITS'(bang);
    return req;
  endfunction

  function automatic int pick_span();
    case ($urandom_range(3))
      0: return 15;
      1: return 255;
      2: return 4095;
      default: return 32767;
    endcase
  endfunction

  function automatic obb_in_t random_box_pair();
    int kind;
    int span;
    int off;
    int ax, ay, aw, ah, bw, bh;
    int qa, qb;
    int gap;
    int side;
    kind = $urandom_range(9);
    if (kind <= 1) begin
      return box_pair($urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (kind <= 6) begin
      // nearby boxes: separation and overlap both likely
      span = pick_span();
      ax   = $urandom;
      ay   = $urandom;
      off  = 3 * span;
      return box_pair(ax, ay, $urandom_range(span), $urandom_range(span), $urandom,
                      ax + int'($urandom_range(2 * off)) - off,
                      ay + int'($urandom_range(2 * off)) - off,
                      $urandom_range(span), $urandom_range(span), $urandom);
    end else if (kind <= 8) begin
      // quarter-turn boxes placed exactly touching or one unit apart
      qa   = $urandom_range(3);
      qb   = $urandom_range(3);
      aw   = $urandom_range(4000);
      ah   = $urandom_range(4000);
      bw   = $urandom_range(4000);
      bh   = $urandom_range(4000);
      ax   = int'($urandom_range(16000)) - 8000;
      ay   = int'($urandom_range(16000)) - 8000;
      side = $urandom_range(1) ? 1 : -1;
      if ($urandom_range(1)) begin
        gap = side * ((qa % 2 ? ah : aw) + (qb % 2 ? bh : bw) + int'($urandom_range(1)));
        return box_pair(ax, ay, aw, ah, qa * QUARTER,
                        ax + gap, ay + int'($urandom_range(200)) - 100, bw, bh, qb * QUARTER);
      end
      gap = side * ((qa % 2 ? aw : ah) + (qb % 2 ? bw : bh) + int'($urandom_range(1)));
      return box_pair(ax, ay, aw, ah, qa * QUARTER,
                      ax + int'($urandom_range(200)) - 100, ay + gap, bw, bh, qb * QUARTER);
    end
    return box_pair(int'($urandom_range(128)) - 64, int'($urandom_range(128)) - 64,
                    $urandom_range(40), $urandom_range(40), $urandom,
                    int'($urandom_range(128)) - 64, int'($urandom_range(128)) - 64,
                    $urandom_range(40), $urandom_range(40), $urandom);
  endfunction

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic issue_pair(input obb_in_t req);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start  = 1'b1;
    in_req = req;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    start = 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_req          = '0;
    sender_idle_pct = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    issue_pair(box_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    issue_pair(box_pair(-32768, -32768, 32767, 32767, 4095,
                        32767, 32767, 32767, 32767, 4095));
    issue_pair(box_pair(-32768, 0, 0, 0, 0, 32767, 0, 0, 0, 0));
    issue_pair(box_pair(0, -32768, 0, 0, 0, 0, 32767, 0, 0, 0));
    issue_pair(box_pair(32767, 0, 32767, 10, 0, -32768, 0, 32767, 10, 0));
    issue_pair(box_pair(32767, 32767, 32767, 32767, 3072,
                        -32768, -32768, 32767, 32767, 1024));
    issue_pair(box_pair(0, 0, 10, 10, 0, 20, 0, 10, 10, 0));
    issue_pair(box_pair(0, 0, 10, 10, 0, 21, 0, 10, 10, 0));
    issue_pair(box_pair(0, 0, 10, 10, 0, 0, 20, 10, 10, 0));
    issue_pair(box_pair(0, 0, 10, 10, 0, 0, -21, 10, 10, 0));
    issue_pair(box_pair(0, 0, 10, 10, 0, 11, 11, 1, 1, 512));
    issue_pair(box_pair(0, 0, 10, 10, 0, 11, 11, 1, 1, 1536));
    issue_pair(box_pair(100, -50, 300, 40, 1024, -200, 80, 25, 500, 2048));
    issue_pair(box_pair(100, -50, 300, 40, 3072, -200, 80, 25, 500, 4095));
    issue_pair(box_pair(-7, 3, 60, 5, 1023, 40, 30, 5, 60, 1));
    issue_pair(box_pair(0, 0, 0, 50, 0, 0, 60, 0, 10, 3072));
    issue_pair(box_pair(0, 0, 50, 0, 2048, 51, 0, 0, 0, 1024));
    issue_pair(box_pair(5, 5, 32767, 32767, 2048, 5, 5, 32767, 32767, 2048));
    issue_pair(box_pair(0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    issue_pair(box_pair(-1000, 2000, 1000, 0, 1024, -1000, 3000, 0, 0, 0));

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = PHASE_IDLE[phase];
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        issue_pair(random_box_pair());
      // hold requests until the pipeline is empty
      drain_results();
    end

    start = 1'b0;
    wait (pending == 0);
    repeat (PIPE_LAT + 4) @(posedge clk);
    if (fail_count == 0)
      $display("PASS obb_overlap_test_2d_unit");
    else
      $display("FAIL obb_overlap_test_2d_unit");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL obb_overlap_test_2d_unit");
    $finish;
  end

endmodule

>>> filelist.f
rtl/obb_pkg.sv
rtl/obb_trig.sv
rtl/obb_proj.sv
rtl/obb_sep.sv
rtl/obb_overlap_test_2d_unit.sv
rtl/obb_overlap_test_2d_unit_chk.sv
tb/sv/obb_overlap_test_2d_unit_checker.sv
tb/sv/obb_overlap_test_2d_unit_tb.sv
